/* src/euler_to_quaternion_assert.svh */
// Assertion macros for the attitude conversion top level
`ifndef EULER_TO_QUATERNION_ASSERT_SVH
`define EULER_TO_QUATERNION_ASSERT_SVH

// condition must hold in the same cycle
`define E2Q_ASSERT_NOW(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// condition must hold in the next cycle
`define E2Q_ASSERT_NEXT(label, clk_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/e2q_pkg.sv */
// Shared constants and helpers for the Euler angle to quaternion converter
`timescale 1ns / 1ps

package e2q_pkg;

  localparam int ANGLE_BITS_DEF    = 16;
  localparam int OUT_FRAC_BITS_DEF = 14;

  localparam int SERIES_STEPS = 6;
  localparam int RECIP_SHIFT  = 31;

  localparam logic [31:0] Q31_ONE  = 32'h8000_0000;
  localparam logic [31:0] Q31_HALF = 32'h4000_0000;
  localparam logic [31:0] PI_Q30   = 32'd3373259426;

  // three front stages, three per series step, two back stages
  localparam int SC_LAT  = 3 + 3 * SERIES_STEPS + 2;
  localparam int MIX_LAT = 6;

  typedef struct packed {
    logic        en;
  } e2q_ctrl_t;

  // Horner divisors, innermost term first
  function automatic logic [7:0] sin_div(input int k);
    logic [7:0] d;
    case (k)
      0:       d = 8'd156;
      1:       d = 8'd110;
      2:       d = 8'd72;
      3:       d = 8'd42;
      4:       d = 8'd20;
      default: d = 8'd6;
    endcase
    return d;
  endfunction

  function automatic logic [7:0] cos_div(input int k);
    logic [7:0] d;
    case (k)
      0:       d = 8'd132;
      1:       d = 8'd90;
      2:       d = 8'd56;
      3:       d = 8'd30;
      4:       d = 8'd12;
      default: d = 8'd2;
    endcase
    return d;
  endfunction

endpackage

/* src/e2q_sincos.sv */
// Pipelined half-angle sine and cosine, Horner Taylor series in Q31
`timescale 1ns / 1ps

module e2q_sincos #(
  parameter int ANGLE_BITS = e2q_pkg::ANGLE_BITS_DEF
) (
  input  logic                   clk,
  input  e2q_pkg::e2q_ctrl_t     ctrl,
  input  logic [ANGLE_BITS-1:0]  angle,
  output logic signed [32:0]     sin_q,
  output logic signed [32:0]     cos_q
);
  import e2q_pkg::*;

  typedef struct packed {
    logic [30:0] x;
    logic [30:0] x2;
    logic        swap;
    logic        neg;
  } sc_ctx_t;

  // front: fold the phase into [0, pi/4]
  logic                  a_neg;
  logic [ANGLE_BITS-1:0] a_mag;
  logic [31:0]           a_f;
  logic [31:0]           a_g_full;
  logic                  a_swap;
  logic [30:0]           a_g;
  logic                  b_neg, b_swap;
  logic [30:0]           b_x;
  logic [62:0]           b_prod;
  logic [30:0]           c_x_next;
  logic [61:0]           c_prod;
  logic [30:0]           c_x2_next;

  always_comb begin
    a_neg    = angle[ANGLE_BITS-1];
    a_mag    = a_neg ? (~angle + 1'b1) : angle;
    a_f      = 32'(a_mag) << (32 - ANGLE_BITS);
    a_swap   = a_f > Q31_HALF;
    a_g_full = a_swap ? (Q31_ONE - a_f) : a_f;
  end

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      a_g    <= a_g_full[30:0];
      b_swap <= a_swap;
      b_neg  <= a_neg;
    end
  end

  logic s1_neg, s1_swap;
  always_comb begin
    b_prod   = 63'(a_g) * 63'(PI_Q30);
    c_x_next = 31'((b_prod + 63'(Q31_HALF)) >> 31);
  end

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      b_x     <= c_x_next;
      s1_swap <= b_swap;
      s1_neg  <= b_neg;
    end
  end

  sc_ctx_t ctx [0:SERIES_STEPS];
  logic [31:0] ts [0:SERIES_STEPS];
  logic [31:0] tc [0:SERIES_STEPS];

  always_comb begin
    c_prod    = 62'(b_x) * 62'(b_x);
    c_x2_next = 31'((c_prod + 62'(Q31_HALF)) >> 31);
  end

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      ctx[0] <= '{x: b_x, x2: c_x2_next, swap: s1_swap, neg: s1_neg};
    end
  end

  assign ts[0] = Q31_ONE;
  assign tc[0] = Q31_ONE;

  genvar k;
  generate
    for (k = 0; k < SERIES_STEPS; k++) begin : g_step
      localparam logic [7:0]  DS = sin_div(k);
      localparam logic [7:0]  DC = cos_div(k);
      localparam logic [30:0] RS = 31'((64'd1 << RECIP_SHIFT) / DS);
      localparam logic [30:0] RC = 31'((64'd1 << RECIP_SHIFT) / DC);

      sc_ctx_t     ctx1, ctx2;
      logic [62:0] ps, pc;
      logic [30:0] ms, mc;
      logic [61:0] ls, lc;
      logic [30:0] ms_next, mc_next;
      logic [30:0] qs0, qc0;
      logic [38:0] rs, rc;
      logic [31:0] qs, qc;

      // x2 times previous term
      always_ff @(posedge clk) begin
        if (ctrl.en) begin
          ps   <= 63'(ctx[k].x2) * 63'(ts[k]);
          pc   <= 63'(ctx[k].x2) * 63'(tc[k]);
          ctx1 <= ctx[k];
        end
      end

      // round, then multiply by reciprocal of divisor
      always_comb begin
        ms_next = 31'((ps + 63'(Q31_HALF)) >> 31);
        mc_next = 31'((pc + 63'(Q31_HALF)) >> 31);
      end

      always_ff @(posedge clk) begin
        if (ctrl.en) begin
          ms   <= ms_next;
          mc   <= mc_next;
          ls   <= 62'(ms_next) * 62'(RS);
          lc   <= 62'(mc_next) * 62'(RC);
          ctx2 <= ctx1;
        end
      end

      // quotient estimate is exact or one low
      always_comb begin
        qs0 = 31'(ls >> RECIP_SHIFT);
        qc0 = 31'(lc >> RECIP_SHIFT);
        rs  = 39'(ms) - 39'(qs0) * 39'(DS);
        rc  = 39'(mc) - 39'(qc0) * 39'(DC);
        qs  = 32'(qs0) + ((rs >= 39'(DS)) ? 32'd1 : 32'd0);
        qc  = 32'(qc0) + ((rc >= 39'(DC)) ? 32'd1 : 32'd0);
      end

      always_ff @(posedge clk) begin
        if (ctrl.en) begin
          ts[k+1]  <= Q31_ONE - qs;
          tc[k+1]  <= Q31_ONE - qc;
          ctx[k+1] <= ctx2;
        end
      end
    end
  endgenerate

  // back: sine = x * series, swap octant, restore sign
  logic [62:0] f_ps;
  logic [31:0] f_tc;
  logic        f_swap, f_neg;
  logic [31:0] f_sv, f_smag, f_cmag;

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      f_ps   <= 63'(ctx[SERIES_STEPS].x) * 63'(ts[SERIES_STEPS]);
      f_tc   <= tc[SERIES_STEPS];
      f_swap <= ctx[SERIES_STEPS].swap;
      f_neg  <= ctx[SERIES_STEPS].neg;
    end
  end

  always_comb begin
    f_sv   = 32'((f_ps + 63'(Q31_HALF)) >> 31);
    f_smag = f_swap ? f_tc : f_sv;
    f_cmag = f_swap ? f_sv : f_tc;
  end

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      sin_q <= f_neg ? -$signed({1'b0, f_smag}) : $signed({1'b0, f_smag});
      cos_q <= $signed({1'b0, f_cmag});
    end
  end

endmodule

/* src/e2q_mix.sv */
// Quaternion products, sums, rounding and clamping
`timescale 1ns / 1ps

module e2q_mix #(
  parameter int OUT_FRAC_BITS = e2q_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  e2q_pkg::e2q_ctrl_t            ctrl,
  input  logic signed [32:0]            sr,
  input  logic signed [32:0]            cr,
  input  logic signed [32:0]            sp,
  input  logic signed [32:0]            cp,
  input  logic signed [32:0]            sy,
  input  logic signed [32:0]            cy,
  output logic [OUT_FRAC_BITS+1:0]      quat_w,
  output logic [OUT_FRAC_BITS+1:0]      quat_x,
  output logic [OUT_FRAC_BITS+1:0]      quat_y,
  output logic [OUT_FRAC_BITS+1:0]      quat_z
);
  import e2q_pkg::*;

  localparam int OW = OUT_FRAC_BITS + 2;
  localparam int SH = 31 - OUT_FRAC_BITS;

  function automatic logic [31:0] mag_of(input logic signed [32:0] v);
    logic [32:0] m;
    m = v[32] ? 33'(-v) : 33'(v);
    return m[31:0];
  endfunction

  function automatic logic [31:0] rnd31(input logic [63:0] p);
    return 32'((p + 64'(Q31_HALF)) >> 31);
  endfunction

  function automatic logic [OW-1:0] to_out(input logic signed [34:0] v);
    logic [34:0] m, r;
    m = v[34] ? 35'(-v) : 35'(v);
    r = (m + (35'd1 << (SH - 1))) >> SH;
    if (r > (35'd1 << OUT_FRAC_BITS)) begin
      r = 35'd1 << OUT_FRAC_BITS;
    end
    return v[34] ? OW'(35'd0 - r) : OW'(r);
  endfunction

  // stage 1: roll by pitch
  logic [63:0] p_cc, p_ss, p_sc, p_cs;
  logic        n_cc, n_ss, n_sc, n_cs;
  logic [31:0] y_c1, y_s1, y_c2, y_s2;
  logic        y_cn1, y_sn1, y_cn2, y_sn2;

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      p_cc  <= 64'(mag_of(cr)) * 64'(mag_of(cp));
      p_ss  <= 64'(mag_of(sr)) * 64'(mag_of(sp));
      p_sc  <= 64'(mag_of(sr)) * 64'(mag_of(cp));
      p_cs  <= 64'(mag_of(cr)) * 64'(mag_of(sp));
      n_cc  <= cr[32] ^ cp[32];
      n_ss  <= sr[32] ^ sp[32];
      n_sc  <= sr[32] ^ cp[32];
      n_cs  <= cr[32] ^ sp[32];
      y_c1  <= mag_of(cy);
      y_s1  <= mag_of(sy);
      y_cn1 <= cy[32];
      y_sn1 <= sy[32];
    end
  end

  // stage 2: round pair products
  logic [31:0] r_cc, r_ss, r_sc, r_cs;
  logic        m_cc, m_ss, m_sc, m_cs;

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      r_cc  <= rnd31(p_cc);
      r_ss  <= rnd31(p_ss);
      r_sc  <= rnd31(p_sc);
      r_cs  <= rnd31(p_cs);
      m_cc  <= n_cc;
      m_ss  <= n_ss;
      m_sc  <= n_sc;
      m_cs  <= n_cs;
      y_c2  <= y_c1;
      y_s2  <= y_s1;
      y_cn2 <= y_cn1;
      y_sn2 <= y_sn1;
    end
  end

  // stage 3: times yaw, eight triple products
  logic [63:0] t  [0:7];
  logic        tn [0:7];

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      t[0] <= 64'(r_cc) * 64'(y_c2);  tn[0] <= m_cc ^ y_cn2;
      t[1] <= 64'(r_ss) * 64'(y_s2);  tn[1] <= m_ss ^ y_sn2;
      t[2] <= 64'(r_sc) * 64'(y_c2);  tn[2] <= m_sc ^ y_cn2;
      t[3] <= 64'(r_cs) * 64'(y_s2);  tn[3] <= m_cs ^ y_sn2;
      t[4] <= 64'(r_cs) * 64'(y_c2);  tn[4] <= m_cs ^ y_cn2;
      t[5] <= 64'(r_sc) * 64'(y_s2);  tn[5] <= m_sc ^ y_sn2;
      t[6] <= 64'(r_cc) * 64'(y_s2);  tn[6] <= m_cc ^ y_sn2;
      t[7] <= 64'(r_ss) * 64'(y_c2);  tn[7] <= m_ss ^ y_cn2;
    end
  end

  // stage 4: round and sign
  logic signed [33:0] u [0:7];

  genvar i;
  generate
    for (i = 0; i < 8; i++) begin : g_tri
      logic [33:0] um;
      assign um = 34'(rnd31(t[i]));
      always_ff @(posedge clk) begin
        if (ctrl.en) begin
          u[i] <= tn[i] ? -$signed(um) : $signed(um);
        end
      end
    end
  endgenerate

  // stage 5: exact sums
  logic signed [34:0] sw, sx, sy_s, sz;

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      sw   <= 35'(u[0]) + 35'(u[1]);
      sx   <= 35'(u[2]) - 35'(u[3]);
      sy_s <= 35'(u[4]) + 35'(u[5]);
      sz   <= 35'(u[6]) - 35'(u[7]);
    end
  end

  // stage 6: round half away from zero, clamp at one
  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      quat_w <= to_out(sw);
      quat_x <= to_out(sx);
      quat_y <= to_out(sy_s);
      quat_z <= to_out(sz);
    end
  end

endmodule

/* src/euler_to_quaternion.sv */
// Top level: ZYX Euler angles to attitude quaternion, fully pipelined
//
// Slave stream s_*: one request per beat carrying roll, pitch and yaw as
// two's complement binary angles (half scale of the angle width is pi).
// Master stream m_*: the matching quaternion w, x, y, z in signed fixed
// point with OUT_FRAC_BITS fraction bits, clamped to +/-1.0.
// From acceptance to m_tvalid a request passes the sine/cosine pipeline
// (three folding stages, three per Taylor step over six Horner steps, two
// back stages), then the product and rounding pipeline. Throughput is one
// request per cycle unless the output stalls; every stage is a plain register.
// The whole pipeline moves on one enable: it advances whenever the output
// register is empty or being taken. A stall at m_tready freezes every stage,
// so s_tready drops in the same cycle and nothing is lost or repeated.
// Bubbles travel as cleared valid bits and never block the flow.
// Reset (rst, synchronous, active high) clears the valid bits only; the
// data registers keep whatever they held and are masked by valid.
`timescale 1ns / 1ps

module euler_to_quaternion #(
  parameter int ANGLE_BITS    = e2q_pkg::ANGLE_BITS_DEF,
  parameter int OUT_FRAC_BITS = e2q_pkg::OUT_FRAC_BITS_DEF,
  localparam int IN_W  = ((3 * ANGLE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((4 * (OUT_FRAC_BITS + 2) + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // roll_angle, pitch_angle, yaw_angle from bit 0, zero padded
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // quat_w, quat_x, quat_y, quat_z from bit 0, zero padded
  output logic [OUT_W-1:0] m_tdata
);
  import e2q_pkg::*;

  localparam int LAT = SC_LAT + MIX_LAT;
  localparam int OW  = OUT_FRAC_BITS + 2;
  localparam int AB  = ANGLE_BITS;

  e2q_ctrl_t ctrl;
  logic [LAT-1:0] vld;

  logic signed [32:0] sr, cr, sp, cp, sy, cy;
  logic [OW-1:0] qw, qx, qy, qz;

  // one enable for the whole pipe: move unless the output is held
  assign ctrl.en  = !vld[LAT-1] || m_tready;
  assign s_tready = ctrl.en;
  assign m_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ctrl.en) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  e2q_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_roll (
    .clk(clk), .ctrl(ctrl), .angle(s_tdata[AB-1:0]), .sin_q(sr), .cos_q(cr)
  );

  e2q_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_pitch (
    .clk(clk), .ctrl(ctrl), .angle(s_tdata[2*AB-1:AB]), .sin_q(sp), .cos_q(cp)
  );

  e2q_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_yaw (
    .clk(clk), .ctrl(ctrl), .angle(s_tdata[3*AB-1:2*AB]), .sin_q(sy), .cos_q(cy)
  );

  e2q_mix #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_mix (
    .clk(clk), .ctrl(ctrl),
    .sr(sr), .cr(cr), .sp(sp), .cp(cp), .sy(sy), .cy(cy),
    .quat_w(qw), .quat_x(qx), .quat_y(qy), .quat_z(qz)
  );

  assign m_tdata = OUT_W'({qz, qy, qx, qw});

  // checks
`include "euler_to_quaternion_assert.svh"

  `E2Q_ASSERT_NEXT(a_reset_empty, clk, rst, !m_tvalid, "output valid after reset")
  `E2Q_ASSERT_NOW(a_stall_blocks, clk, rst, m_tvalid && !m_tready, !s_tready, "request taken during stall")
  `E2Q_ASSERT_NOW(a_w_range, clk, rst, m_tvalid, ($signed(qw) <= $signed(OW'(1) << OUT_FRAC_BITS)) && ($signed(qw) >= -$signed(OW'(1) << OUT_FRAC_BITS)), "quat_w beyond one")

endmodule

/* tb/tb_euler_to_quaternion.sv */
// Testbench for the Euler angle to quaternion converter: directed and random requests
`timescale 1ns / 1ps

class quat_scoreboard;
  bit [63:0] pending[$];
  int mismatches;

  // sine and cosine (signed Q31) of the half angle
  static function void half_trig(input logic [15:0] raw, output longint s, output longint c);
    longint unsigned sdiv[6], cdiv[6];
    longint unsigned mag, f, g, x, x2, ts, tc, sv, cv, t;
    bit neg, swap;
    sdiv = '{156, 110, 72, 42, 20, 6};
    cdiv = '{132, 90, 56, 30, 12, 2};
    neg = raw[15];
    mag = neg ? (64'h10000 - raw) : raw;
    f = mag << 16;
    swap = f > (64'd1 << 30);
    g = swap ? ((64'd1 << 31) - f) : f;
    x = (g * 64'd3373259426 + (64'd1 << 30)) >> 31;
    x2 = qmul(x, x);
    ts = 64'd1 << 31;
    tc = 64'd1 << 31;
    for (int k = 0; k < 6; k++) begin
      ts = (64'd1 << 31) - qmul(x2, ts) / sdiv[k];
      tc = (64'd1 << 31) - qmul(x2, tc) / cdiv[k];
    end
    sv = qmul(x, ts);
    cv = tc;
    if (swap) begin
      t = sv; sv = cv; cv = t;
    end
    s = neg ? -longint'(sv) : longint'(sv);
    c = longint'(cv);
  endfunction

  static function longint unsigned qmul(longint unsigned a, longint unsigned b);
    return (a * b + (64'd1 << 30)) >> 31;
  endfunction

  static function longint smul(longint a, longint b);
    longint unsigned m;
    m = qmul(a < 0 ? -a : a, b < 0 ? -b : b);
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  static function logic [15:0] to_q14(longint v);
    longint unsigned m, r;
    m = v < 0 ? -v : v;
    r = (m + (64'd1 << 16)) >> 17;
    if (r > 16384) r = 16384;
    return v < 0 ? 16'(-r) : 16'(r);
  endfunction

  function void note_request(logic [47:0] d);
    longint sr, cr, sp, cp, sy, cy;
    bit [63:0] q;
    half_trig(d[15:0], sr, cr);
    half_trig(d[31:16], sp, cp);
    half_trig(d[47:32], sy, cy);
    q[15:0]  = to_q14(smul(smul(cr, cp), cy) + smul(smul(sr, sp), sy));
    q[31:16] = to_q14(smul(smul(sr, cp), cy) - smul(smul(cr, sp), sy));
    q[47:32] = to_q14(smul(smul(cr, sp), cy) + smul(smul(sr, cp), sy));
    q[63:48] = to_q14(smul(smul(cr, cp), sy) - smul(smul(sr, sp), cy));
    pending.push_back(q);
  endfunction

  function void check_result(logic [63:0] got);
    bit [63:0] q;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected quaternion %h", got);
      return;
    end
    q = pending.pop_front();
    for (int i = 0; i < 4; i++)
      if (got[16*i +: 16] !== q[16*i +: 16]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("component %0d: expected %h got %h", i, q[16*i +: 16], got[16*i +: 16]);
      end
  endfunction
endclass

module tb_euler_to_quaternion;
  localparam int NUM_RANDOM = 1300;
  localparam int CALM_FROM = 1100;
  localparam int LIMIT = 400000;

  logic clk = 0, rst = 1;
  logic s_tvalid = 0, m_tready = 0;
  logic [47:0] s_tdata = '0;
  logic s_tready, m_tvalid;
  logic [63:0] m_tdata;

  quat_scoreboard sb = new();
  int cycles = 0;
  int sent = 0;
  bit stim_done = 0;

  euler_to_quaternion dut (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb_euler_to_quaternion: done, errors");
      $finish;
    end
  end

  // sink with stall bursts, none late in the run
  initial begin
    int hold;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (sent < CALM_FROM && $urandom_range(0, 3) == 0) begin
        hold = $urandom_range(1, 14);
        m_tready <= 0;
        repeat (hold) @(posedge clk);
      end
      m_tready <= 1;
      @(posedge clk);
    end
  end

  always @(posedge clk)
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'(16'h4000 + $urandom_range(0, 8) - 4);
      4: return 16'(16'hc000 + $urandom_range(0, 8) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  // one request held until accepted
  task automatic send_request(logic [47:0] d);
    s_tvalid <= 1;
    s_tdata <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_request(d);
    sent++;
  endtask

  task automatic idle_gap();
    if (sent < CALM_FROM && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  initial begin
    logic [15:0] edges[7];
    edges = '{16'h0000, 16'h8000, 16'h7fff, 16'h4000, 16'hc000, 16'h0001, 16'hffff};
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    for (int i = 0; i < 7; i++) begin
      send_request({edges[(i + 2) % 7], edges[(i + 1) % 7], edges[i]});
      idle_gap();
    end
    send_request({16'h8000, 16'h8000, 16'h8000});
    send_request({16'h7fff, 16'h7fff, 16'h7fff});
    send_request({16'h2000, 16'h4000, 16'h6000});
    for (int n = 0; n < NUM_RANDOM; n++) begin
      send_request({pick_angle(), pick_angle(), pick_angle()});
      idle_gap();
    end
    s_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("tb_euler_to_quaternion: done, clean");
    else
      $display("tb_euler_to_quaternion: done, errors");
    $finish;
  end
endmodule

/* sim.f */
+incdir+src
src/e2q_pkg.sv
src/e2q_sincos.sv
src/e2q_mix.sv
src/euler_to_quaternion.sv
tb/tb_euler_to_quaternion.sv
